### rtl/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and codes for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_LEVEL_DEF       = 10;
    localparam int MIN_BLOCK_BYTES_DEF = 1024;
    localparam int HEADER_BYTES        = 16;

    // register indexes
    localparam logic REG_POOL_BASE  = 1'b0;
    localparam logic REG_POOL_BYTES = 1'b1;

    // opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ALLOC_OK   = 2'd0;
    localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
    localparam logic [1:0] ST_FREE_DONE  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CFG_LEVEL,
        S_CFG_CLEAR,
        S_CFG_SEED,
        S_A_WANT,
        S_A_SCAN,
        S_A_POP_RD,
        S_A_POP_WAIT,
        S_A_POP,
        S_A_SPLIT,
        S_A_DONE,
        S_F_TAG_RD,
        S_F_TAG_WAIT,
        S_F_TAG,
        S_F_WALK_START,
        S_F_WALK_RD,
        S_F_WALK_WAIT,
        S_F_WALK,
        S_F_UNLINK,
        S_F_PUSH,
        S_RESULT
    } bba_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic cfg_level_init;
        logic cfg_level_step;
        logic clear_heads;
        logic seed_top;
        logic want_init;
        logic want_step;
        logic scan_init;
        logic scan_step;
        logic pop_read;
        logic pop_commit;
        logic split_push;
        logic alloc_tag;
        logic tag_read;
        logic tag_load;
        logic walk_start;
        logic walk_read;
        logic walk_step;
        logic unlink;
        logic merge;
        logic push_free;
        logic load_result;
        logic [1:0] result_status;
        logic capture;
    } bba_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic pool_valid;
        logic cfg_level_done;
        logic req_zero;
        logic want_done;
        logic want_over;
        logic scan_found;
        logic scan_over;
        logic split_done;
        logic at_top;
        logic walk_hit;
        logic walk_end;
    } bba_stat_t;

endpackage

### rtl/bba_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface bba_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/bba_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_datapath
// Pool registers, free list heads, link and tag memories, address math.
// ----------------------------------------------------------------------------
module bba_datapath #(
    parameter int MAX_LEVEL       = bba_pkg::MAX_LEVEL_DEF,
    parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bba_pkg::bba_cmd_t cmd,
    output bba_pkg::bba_stat_t stat,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic              in_opcode,
    input  logic [31:0]       in_request_bytes,
    input  logic [63:0]       in_release_address,
    output logic              op_free,
    output logic [1:0]        out_status,
    output logic [63:0]       out_granted_address
);
    import bba_pkg::*;

    localparam int NBLK  = 1 << MAX_LEVEL;
    localparam int NLEV  = MAX_LEVEL + 1;
    localparam int BW    = MAX_LEVEL;
    localparam int LW    = $clog2(NLEV + 1);
    localparam int SHIFT = $clog2(MIN_BLOCK_BYTES);
    localparam int STEPW = MAX_LEVEL + 2;

    logic [63:0] pool_base_reg;
    logic [31:0] pool_bytes_reg;
    logic [LW-1:0] top_level_reg;
    logic pool_valid_reg;
    logic [NLEV-1:0] head_ok_reg;
    logic [BW-1:0] head_reg [NLEV];

    logic [BW-1:0] link_mem [NBLK];
    logic          link_nil_mem [NBLK];
    logic [LW-1:0] tag_mem [NBLK];
    logic [BW-1:0] link_rd_reg;
    logic          link_nil_rd_reg;
    logic [LW-1:0] tag_rd_reg;

    logic          opcode_reg;
    logic [32:0]   need_reg;
    logic [63:0]   addr_reg;
    logic [LW-1:0] want_reg;
    logic [LW-1:0] lev_reg;
    logic [BW-1:0] blk_reg;
    logic [BW-1:0] bud_reg;
    logic [BW-1:0] cur_reg;
    logic          cur_nil_reg;
    logic [BW-1:0] prev_reg;
    logic          prev_nil_reg;
    logic [STEPW-1:0] steps_reg;
    logic [1:0]    status_reg;
    logic [63:0]   grant_reg;

    logic [63:0] aligned_base;
    logic [63:0] free_off;
    logic [BW-1:0] bud_next;
    logic [42:0] lev_bytes_want;
    logic [42:0] lev_bytes_next;

    assign aligned_base = (pool_base_reg + 64'd7) & ~64'd7;
    assign free_off     = addr_reg - 64'd16 - aligned_base;
    assign lev_bytes_want = 43'(MIN_BLOCK_BYTES) << want_reg;
    assign lev_bytes_next = 43'(MIN_BLOCK_BYTES) << (lev_reg + 1'b1);
    assign bud_next = blk_reg ^ BW'(NBLK'(1) << lev_reg);

    // status
    always_comb
    begin
        stat.pool_valid     = pool_valid_reg;
        stat.cfg_level_done = (lev_reg >= LW'(MAX_LEVEL))
                              || (lev_bytes_next > 43'(pool_bytes_reg));
        stat.req_zero       = (need_reg == 33'd16);
        stat.want_done      = (43'(need_reg) <= lev_bytes_want);
        stat.want_over      = (want_reg > top_level_reg);
        stat.scan_over      = (lev_reg > top_level_reg);
        stat.scan_found     = !stat.scan_over && head_ok_reg[lev_reg];
        stat.split_done     = (lev_reg == want_reg);
        stat.at_top         = (lev_reg >= top_level_reg);
        stat.walk_end       = cur_nil_reg || (steps_reg > STEPW'(NBLK));
        stat.walk_hit       = !stat.walk_end && (cur_reg == bud_reg);
    end

    assign op_free             = opcode_reg;
    assign out_status          = status_reg;
    assign out_granted_address = grant_reg;

    // configuration and pool control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg  <= '0;
            pool_bytes_reg <= '0;
            top_level_reg  <= '0;
            pool_valid_reg <= 1'b0;
            head_ok_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_POOL_BASE)
                    pool_base_reg <= cfg_data;
                else
                    pool_bytes_reg <= cfg_data[31:0];
            end
            if (cmd.clear_heads)
            begin
                head_ok_reg    <= '0;
                pool_valid_reg <= (pool_bytes_reg >= 32'(MIN_BLOCK_BYTES));
                top_level_reg  <= (pool_bytes_reg >= 32'(MIN_BLOCK_BYTES)) ? lev_reg : '0;
            end
            if (cmd.seed_top)
                head_ok_reg[top_level_reg] <= 1'b1;
            if (cmd.pop_commit)
                head_ok_reg[lev_reg] <= !link_nil_rd_reg;
            if (cmd.split_push || cmd.push_free)
                head_ok_reg[cmd.split_push ? lev_reg - 1'b1 : lev_reg] <= 1'b1;
            if (cmd.unlink && prev_nil_reg)
                head_ok_reg[lev_reg] <= !link_nil_rd_reg;
        end
    end

    // head registers
    always_ff @(posedge clk)
    begin
        if (cmd.seed_top)
            head_reg[top_level_reg] <= '0;
        if (cmd.pop_commit)
            head_reg[lev_reg] <= link_rd_reg;
        if (cmd.split_push)
            head_reg[lev_reg - 1'b1] <= blk_reg ^ BW'(NBLK'(1) << (lev_reg - 1'b1));
        if (cmd.push_free)
            head_reg[lev_reg] <= blk_reg;
        if (cmd.unlink && prev_nil_reg)
            head_reg[lev_reg] <= link_rd_reg;
    end

    // link and tag memories
    always_ff @(posedge clk)
    begin
        if (cmd.seed_top)
        begin
            link_nil_mem[0] <= 1'b1;
            link_mem[0]     <= '0;
            tag_mem[0]      <= top_level_reg;
        end
        else if (cmd.split_push)
        begin
            link_mem[blk_reg ^ BW'(NBLK'(1) << (lev_reg - 1'b1))] <=
                head_reg[lev_reg - 1'b1];
            link_nil_mem[blk_reg ^ BW'(NBLK'(1) << (lev_reg - 1'b1))] <=
                !head_ok_reg[lev_reg - 1'b1];
        end
        else if (cmd.push_free)
        begin
            link_mem[blk_reg]     <= head_reg[lev_reg];
            link_nil_mem[blk_reg] <= !head_ok_reg[lev_reg];
        end
        else if (cmd.unlink && !prev_nil_reg)
        begin
            link_mem[prev_reg]     <= link_rd_reg;
            link_nil_mem[prev_reg] <= link_nil_rd_reg;
        end
        if (cmd.split_push)
            tag_mem[blk_reg ^ BW'(NBLK'(1) << (lev_reg - 1'b1))] <= lev_reg - 1'b1;
        else if (cmd.alloc_tag)
            tag_mem[blk_reg] <= want_reg;
        else if (cmd.push_free)
            tag_mem[blk_reg] <= lev_reg;
        // registered reads
        if (cmd.pop_read || cmd.walk_read)
        begin
            link_rd_reg     <= link_mem[cmd.pop_read ? head_reg[lev_reg] : cur_reg];
            link_nil_rd_reg <= link_nil_mem[cmd.pop_read ? head_reg[lev_reg] : cur_reg];
        end
        if (cmd.tag_read)
            tag_rd_reg <= tag_mem[BW'(free_off >> SHIFT)];
    end

    // request and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            opcode_reg <= in_opcode;
            need_reg   <= 33'(in_request_bytes) + 33'd16;
            addr_reg   <= in_release_address;
        end
        if (cmd.cfg_level_init)
            lev_reg <= '0;
        if (cmd.cfg_level_step)
            lev_reg <= lev_reg + 1'b1;
        if (cmd.want_init)
            want_reg <= '0;
        if (cmd.want_step)
            want_reg <= want_reg + 1'b1;
        if (cmd.scan_init)
            lev_reg <= want_reg;
        if (cmd.scan_step)
            lev_reg <= lev_reg + 1'b1;
        if (cmd.pop_read)
            blk_reg <= head_reg[lev_reg];
        if (cmd.split_push)
            lev_reg <= lev_reg - 1'b1;
        if (cmd.tag_load)
        begin
            blk_reg <= BW'(free_off >> SHIFT);
            lev_reg <= (tag_rd_reg > top_level_reg) ? top_level_reg : tag_rd_reg;
        end
        if (cmd.walk_start)
        begin
            bud_reg      <= bud_next;
            cur_reg      <= head_reg[lev_reg];
            cur_nil_reg  <= !head_ok_reg[lev_reg];
            prev_nil_reg <= 1'b1;
            steps_reg    <= '0;
        end
        if (cmd.walk_step)
        begin
            prev_reg     <= cur_reg;
            prev_nil_reg <= 1'b0;
            cur_reg      <= link_rd_reg;
            cur_nil_reg  <= link_nil_rd_reg;
            steps_reg    <= steps_reg + 1'b1;
        end
        if (cmd.merge)
        begin
            if (bud_reg < blk_reg)
                blk_reg <= bud_reg;
            lev_reg <= lev_reg + 1'b1;
        end
        if (cmd.load_result)
        begin
            status_reg <= cmd.result_status;
            grant_reg  <= (cmd.result_status == ST_ALLOC_OK)
                          ? aligned_base + (64'(blk_reg) << SHIFT) + 64'd16 : '0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seed_top |-> pool_valid_reg)
        else $error("seed without valid pool");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_commit |-> head_ok_reg[lev_reg])
        else $error("pop from empty list");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.split_push |-> (lev_reg > want_reg))
        else $error("split below wanted level");
endmodule

### rtl/bba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for rebuild, allocate and free operations.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               in_fire,
    input  logic               op_free,
    input  logic               out_busy,
    input  logic               out_take,
    input  bba_pkg::bba_stat_t stat,
    output bba_pkg::bba_cmd_t  cmd,
    output logic               cfg_ready,
    output logic               in_ready,
    output logic               out_load
);
    import bba_pkg::*;

    bba_state_t state_reg;
    bba_state_t state_next;
    logic [1:0] res_reg;
    logic [1:0] res_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= ST_ALLOC_FAIL;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cfg_ready  = 1'b0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = 1'b1;
                if (cfg_we)
                begin
                    in_ready   = 1'b0;
                    state_next = S_CFG_LEVEL;
                end
                else if (in_fire)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_A_WANT;
                end
            end
            S_CFG_LEVEL:
            begin
                cmd.cfg_level_init = 1'b1;
                state_next = S_CFG_CLEAR;
            end
            S_CFG_CLEAR:
            begin
                if (stat.cfg_level_done)
                begin
                    cmd.clear_heads = 1'b1;
                    state_next = S_CFG_SEED;
                end
                else
                    cmd.cfg_level_step = 1'b1;
            end
            S_CFG_SEED:
            begin
                cmd.seed_top = stat.pool_valid;
                state_next = S_IDLE;
            end
            S_A_WANT:
            begin
                cmd.want_init = 1'b1;
                if (op_free)
                    state_next = stat.pool_valid ? S_F_TAG_RD : S_RESULT;
                else if (stat.req_zero || !stat.pool_valid)
                    state_next = S_RESULT;
                else
                    state_next = S_A_SCAN;
                res_next = op_free ? ST_FREE_DONE : ST_ALLOC_FAIL;
                if (!op_free && !(stat.req_zero || !stat.pool_valid))
                begin
                    cmd.want_init = 1'b1;
                    state_next = S_A_POP_WAIT;
                end
            end
            S_A_POP_WAIT:
            begin
                if (stat.want_over)
                    state_next = S_RESULT;
                else if (stat.want_done)
                begin
                    cmd.scan_init = 1'b1;
                    state_next = S_A_SCAN;
                end
                else
                    cmd.want_step = 1'b1;
            end
            S_A_SCAN:
            begin
                if (stat.scan_over)
                    state_next = S_RESULT;
                else if (stat.scan_found)
                begin
                    cmd.pop_read = 1'b1;
                    state_next = S_A_POP;
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_A_POP:
            begin
                cmd.pop_commit = 1'b1;
                state_next = S_A_SPLIT;
            end
            S_A_SPLIT:
            begin
                if (stat.split_done)
                begin
                    cmd.alloc_tag = 1'b1;
                    res_next = ST_ALLOC_OK;
                    state_next = S_RESULT;
                end
                else
                    cmd.split_push = 1'b1;
            end
            S_F_TAG_RD:
            begin
                cmd.tag_read = 1'b1;
                state_next = S_F_TAG;
            end
            S_F_TAG:
            begin
                cmd.tag_load = 1'b1;
                state_next = S_F_WALK_START;
            end
            S_F_WALK_START:
            begin
                if (stat.at_top)
                    state_next = S_F_PUSH;
                else
                begin
                    cmd.walk_start = 1'b1;
                    state_next = S_F_WALK_RD;
                end
            end
            S_F_WALK_RD:
            begin
                if (stat.walk_end)
                    state_next = S_F_PUSH;
                else
                begin
                    cmd.walk_read = 1'b1;
                    state_next = stat.walk_hit ? S_F_UNLINK : S_F_WALK;
                end
            end
            S_F_WALK:
            begin
                cmd.walk_step = 1'b1;
                state_next = S_F_WALK_RD;
            end
            S_F_UNLINK:
            begin
                cmd.unlink = 1'b1;
                cmd.merge  = 1'b1;
                state_next = S_F_WALK_START;
            end
            S_F_PUSH:
            begin
                cmd.push_free = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_busy || out_take)
                begin
                    cmd.load_result   = 1'b1;
                    cmd.result_status = res_reg;
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> state_reg == S_IDLE)
        else $error("request taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> state_reg == S_RESULT)
        else $error("result loaded outside result state");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_A_WANT)
        else $error("request not started");
endmodule

### rtl/buddy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over power-of-two blocks with per-level free lists.
// ----------------------------------------------------------------------------
// Usage:
//   cfg: write register 0 (pool_base) or 1 (pool_bytes); each write rebuilds
//     the pool as one free top block. Writes are only taken while no request
//     is being worked on.
//   req: opcode, request_bytes, release_address. One request at a time.
//   rsp: status and granted_address, one response per request.
// Sequence: an allocate sizes the request level by level, scans the free
//   lists upward, pops a block and splits it down to the wanted level; a free
//   reads the block's tag and walks the free list at each level for the buddy,
//   merging while it is found. A list walk is bounded by 2^MAX_LEVEL+1 steps.
// Reset: all lists empty, pool unusable; allocates fail, frees report done.
// The response sits in an output register; a new request is taken while it
//   waits, and a second response waits until the first is taken.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
    parameter int MAX_LEVEL       = bba_pkg::MAX_LEVEL_DEF,
    parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
    input logic clk,
    input logic rst_n,
    bba_if.sink   cfg,
    bba_if.sink   req,
    bba_if.source rsp
);
    import bba_pkg::*;

    bba_cmd_t  cmd;
    bba_stat_t stat;
    logic cfg_ready;
    logic cfg_fire;
    logic in_ready;
    logic out_load;
    logic op_free;
    logic rsp_valid_reg;
    logic [1:0]  st;
    logic [63:0] ga;

    assign cfg.ready = cfg_ready;
    assign cfg_fire  = cfg.valid && cfg_ready;
    assign req.ready = in_ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data.status = st;
    assign rsp.data.granted_address = ga;

    // response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (out_load)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_fire),
        .in_fire   (req.valid && in_ready),
        .op_free   (op_free),
        .out_busy  (rsp_valid_reg),
        .out_take  (rsp.ready),
        .stat      (stat),
        .cmd       (cmd),
        .cfg_ready (cfg_ready),
        .in_ready  (in_ready),
        .out_load  (out_load)
    );

    bba_datapath #(
        .MAX_LEVEL       (MAX_LEVEL),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .cfg_we              (cfg_fire),
        .cfg_index           (cfg.data.index == 64'd0 ? REG_POOL_BASE : REG_POOL_BYTES),
        .cfg_data            (cfg.data.value),
        .in_opcode           (req.data.opcode),
        .in_request_bytes    (req.data.request_bytes),
        .in_release_address  (req.data.release_address),
        .op_free             (op_free),
        .out_status          (st),
        .out_granted_address (ga)
    );
endmodule

### bench/bba_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_tb_types
// Request, response and register write formats used on the allocator channels.
// ----------------------------------------------------------------------------
package bba_tb_types;

    typedef struct packed {
        logic        index;
        logic [63:0] value;
    } cfg_write_t;

    typedef struct packed {
        logic        opcode;
        logic [31:0] request_bytes;
        logic [63:0] release_address;
    } alloc_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] granted_address;
    } alloc_rsp_t;

endpackage

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the buddy block allocator against a cycle-free predictor of its
// free lists. Allocates and frees of live blocks run in bursts across
// several pool settings, with random response stalls and one long hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import bba_pkg::*;
    import bba_tb_types::*;

    localparam int LEVELS     = MAX_LEVEL_DEF + 1;
    localparam int BLOCKS     = 1 << MAX_LEVEL_DEF;
    localparam int EMPTY      = BLOCKS;
    localparam int CYCLE_LIMIT = 3000000;

    // free-list predictor and store of expected responses
    class alloc_scoreboard;
        logic [63:0] base_reg;
        logic [31:0] size_reg;
        int          head[LEVELS];
        int          link[BLOCKS];
        int          tag[BLOCKS];
        int          top;
        bit          usable;
        alloc_rsp_t  expected_rsp[$];
        int          mismatches;
        int          n_ok, n_fail, n_free;

        function new();
            base_reg = '0;
            size_reg = '0;
            mismatches = 0;
            n_ok = 0; n_fail = 0; n_free = 0;
            foreach (link[i]) begin
                link[i] = 0;
                tag[i] = 0;
            end
            rebuild();
        endfunction

        function logic [63:0] pool_start();
            return (base_reg + 64'd7) & ~64'd7;
        endfunction

        function void rebuild();
            int k;
            foreach (head[i]) head[i] = EMPTY;
            top = 0;
            usable = 0;
            if (size_reg < MIN_BLOCK_BYTES_DEF) return;
            k = 0;
            while (k < MAX_LEVEL_DEF && (64'(MIN_BLOCK_BYTES_DEF) << (k + 1)) <= size_reg)
                k++;
            top = k;
            usable = 1;
            link[0] = EMPTY;
            head[k] = 0;
            tag[0] = k;
        endfunction

        function void write_reg(logic idx, logic [63:0] value);
            if (idx == REG_POOL_BASE) base_reg = value;
            else size_reg = value[31:0];
            rebuild();
        endfunction

        function void push(int lev, int b);
            b = b & (BLOCKS - 1);
            link[b] = head[lev];
            head[lev] = b;
            tag[b] = lev & 15;
        endfunction

        function bit unlink(int lev, int b);
            int prev, cur, steps;
            prev = EMPTY;
            cur = head[lev];
            steps = 0;
            while (cur < BLOCKS && steps <= BLOCKS) begin
                if (cur == b) begin
                    if (prev == EMPTY) head[lev] = link[cur];
                    else link[prev] = link[cur];
                    return 1;
                end
                prev = cur;
                cur = link[cur];
                steps++;
            end
            return 0;
        endfunction

        // predicts the response of one accepted request
        function alloc_rsp_t note_request(alloc_req_t r);
            alloc_rsp_t  res;
            logic [63:0] need, off;
            int want, lev, b, bud;
            res.status = ST_ALLOC_FAIL;
            res.granted_address = '0;
            if (r.opcode == OP_ALLOC) begin
                if (r.request_bytes != 0 && usable) begin
                    need = 64'(r.request_bytes) + 64'd16;
                    want = 0;
                    while (want <= top && (64'(MIN_BLOCK_BYTES_DEF) << want) < need) want++;
                    lev = want;
                    if (want <= top)
                        while (lev <= top && head[lev] >= BLOCKS) lev++;
                    if (want <= top && lev <= top) begin
                        b = head[lev];
                        head[lev] = link[b];
                        while (lev > want) begin
                            lev--;
                            push(lev, b ^ (1 << lev));
                        end
                        tag[b] = want;
                        res.status = ST_ALLOC_OK;
                        res.granted_address = pool_start() + 64'(b) * MIN_BLOCK_BYTES_DEF
                                              + 64'd16;
                    end
                end
                if (res.status == ST_ALLOC_OK) n_ok++;
                else n_fail++;
            end else begin
                res.status = ST_FREE_DONE;
                n_free++;
                if (usable) begin
                    off = r.release_address - 64'd16 - pool_start();
                    b = int'(off[19:10]);
                    lev = tag[b] & 15;
                    if (lev > top) lev = top;
                    while (lev < top) begin
                        bud = (b ^ (1 << lev)) & (BLOCKS - 1);
                        if (!unlink(lev, bud)) break;
                        if (bud < b) b = bud;
                        lev++;
                    end
                    push(lev, b);
                end
            end
            expected_rsp.push_back(res);
            return res;
        endfunction

        function void check(alloc_rsp_t got);
            alloc_rsp_t want;
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response status=%0d addr=%h",
                             got.status, got.granted_address);
                return;
            end
            want = expected_rsp.pop_front();
            if (got.status !== want.status || got.granted_address !== want.granted_address) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status=%0d addr=%h, got status=%0d addr=%h",
                             want.status, want.granted_address, got.status,
                             got.granted_address);
            end
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles = 0;
    bit   hold_go;
    bit   hold_on;
    int   burst_left;
    int   phases;
    logic [63:0] live[$];
    alloc_scoreboard sb;

    bba_if #(.payload_t(cfg_write_t)) cfg_ch ();
    bba_if #(.payload_t(alloc_req_t)) req_ch ();
    bba_if #(.payload_t(alloc_rsp_t)) rsp_ch ();

    buddy_block_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch.sink),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // response side: stall pattern plus the long hold-off
    always @(posedge clk)
    begin
        int mode;
        mode = (cycles / 500) % 3;
        if (rsp_ch.valid && rsp_ch.ready)
            sb.check(rsp_ch.data);
        if (hold_on)
            rsp_ch.ready <= 1'b0;
        else if (mode == 0)
            rsp_ch.ready <= 1'b1;
        else if (mode == 1)
            rsp_ch.ready <= ($urandom_range(0, 1) == 1);
        else
            rsp_ch.ready <= ($urandom_range(0, 3) == 0);
    end

    // long hold-off, counted here while requests keep coming
    initial
    begin
        hold_on = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (400) @(posedge clk);
        hold_on <= 1'b0;
    end

    task automatic write_reg(logic idx, logic [63:0] value);
        cfg_write_t w;
        w.index = idx;
        w.value = value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= w;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.write_reg(idx, value);
        live.delete();
    endtask

    // send one request and predict its response on acceptance
    task automatic send_request(logic op, logic [31:0] nbytes, logic [63:0] addr);
        alloc_req_t r;
        alloc_rsp_t p;
        r.opcode = op;
        r.request_bytes = nbytes;
        r.release_address = addr;
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do @(posedge clk); while (!req_ch.ready);
        p = sb.note_request(r);
        if (p.status == ST_ALLOC_OK) live.push_back(p.granted_address);
        // bursts with random gaps
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = $urandom_range(1, 60);
        end
        else
            burst_left--;
    endtask

    task automatic free_live();
        int i;
        logic [63:0] a;
        i = $urandom_range(0, live.size() - 1);
        a = live[i];
        live.delete(i);
        send_request(OP_FREE, $urandom, a);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int roll;
        logic [31:0] sz;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40 && live.size() > 0)
                free_live();
            else if (roll < 95)
            begin
                if ($urandom_range(0, 9) < 7)
                    sz = $urandom_range(1, 3000);
                else
                    sz = $urandom_range(1, (MIN_BLOCK_BYTES_DEF << sb.top) - 16);
                send_request(OP_ALLOC, sz, $urandom);
            end
            else if (roll < 97)
                send_request(OP_ALLOC, 32'd0, {$urandom, $urandom});
            else
                send_request(OP_ALLOC, $urandom, {$urandom, $urandom});
        end
        // return live blocks until a random stop so the pool merges back
        while (live.size() > 0 && $urandom_range(0, 3) != 0) free_live();
        drain();
    endtask

    initial
    begin
        sb = new();
        hold_go = 0;
        burst_left = 10;
        phases = 0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unusable pool after reset, zero request
        send_request(OP_ALLOC, 32'd100, '0);
        send_request(OP_FREE, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_ALLOC, 32'd0, '0);
        drain();

        // wrapping base, largest pool
        write_reg(REG_POOL_BASE, 64'hFFFF_FFFF_FFFF_FFF9);
        write_reg(REG_POOL_BYTES, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'd1, '0);
        send_request(OP_ALLOC, 32'd1008, '0);
        send_request(OP_ALLOC, 32'd1009, '0);
        send_request(OP_ALLOC, 32'd0, '0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, '0);
        send_request(OP_ALLOC, 32'd1048576, '0);
        send_request(OP_ALLOC, 32'd1048560, '0);
        send_request(OP_ALLOC, 32'd524272, '0);
        while (live.size() > 0) free_live();
        send_request(OP_ALLOC, 32'd1048560, '0);
        while (live.size() > 0) free_live();
        drain();
        phases++;

        // below one block: unusable
        write_reg(REG_POOL_BYTES, 32'd1023);
        send_request(OP_ALLOC, 32'd1, '0);
        send_request(OP_FREE, 32'd0, 64'd16);
        drain();

        // exactly one minimum block
        write_reg(REG_POOL_BASE, 64'd0);
        write_reg(REG_POOL_BYTES, 32'd1024);
        send_request(OP_ALLOC, 32'd1008, '0);
        send_request(OP_ALLOC, 32'd1, '0);
        while (live.size() > 0) free_live();
        drain();
        random_phase(60);
        phases++;

        // random phases across several settings, hold-off in the first
        write_reg(REG_POOL_BASE, {$urandom, $urandom});
        write_reg(REG_POOL_BYTES, 32'h0010_0000);
        hold_go = 1;
        random_phase(250);
        phases++;
        write_reg(REG_POOL_BYTES, 32'd4096 + $urandom_range(0, 4095));
        random_phase(100);
        phases++;
        write_reg(REG_POOL_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_POOL_BYTES, $urandom);
        random_phase(200);
        phases++;
        write_reg(REG_POOL_BASE, {$urandom, $urandom});
        write_reg(REG_POOL_BYTES, $urandom_range(1024, 300000));
        random_phase(200);
        phases++;
        write_reg(REG_POOL_BYTES, 32'd0);
        send_request(OP_ALLOC, 32'd64, '0);
        send_request(OP_FREE, 32'd0, {$urandom, $urandom});
        drain();

        $display("covered %0d pool settings: %0d allocs granted, %0d refused, %0d frees",
                 phases, sb.n_ok, sb.n_fail, sb.n_free);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
